@@ design/rps_pkg.sv @@
// rps_pkg: shared constants, codes and types of the roast profile sequencer
// no dependencies; used by every other file of the block

package rps_pkg;

  // field widths that do not follow from a parameter
  localparam int OP_BITS      = 2;
  localparam int PIDX_BITS    = 4;
  localparam int PT_ADDR_BITS = 5;
  localparam int SECS_BITS    = 10;
  localparam int SEC_BITS     = 6;
  localparam int STAGE_BITS   = 4;
  localparam int FAN_BITS     = 8;
  localparam int MIN_BITS     = 4;
  localparam int PHASE_BITS   = 2;
  localparam int CFG_IDX_BITS = 8;

  // timing constants
  localparam int SEC_PER_MIN  = 60;
  localparam int HALF_MIN     = 30;

  // reset values
  localparam int RESET_TEMP          = 100;
  localparam int RESET_COOL_THRESH   = 200;
  localparam int RESET_ROAST_MINUTES = 11;
  localparam int RESET_FAN_START     = 165;
  localparam int RESET_FAN_FLOOR     = 146;

  // operation codes
  typedef enum logic [OP_BITS-1:0] {
    OP_SAMPLE = 2'd0,
    OP_TICK   = 2'd1,
    OP_START  = 2'd2,
    OP_WRITE  = 2'd3
  } op_e;

  // phase state codes
  localparam logic [PHASE_BITS-1:0] PH_MENU  = 2'd0;
  localparam logic [PHASE_BITS-1:0] PH_ROAST = 2'd1;
  localparam logic [PHASE_BITS-1:0] PH_COOL  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_COOL_THRESHOLD = 8'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ROAST_MINUTES  = 8'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FAN_START      = 8'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FAN_FLOOR      = 8'd3;

  // profile store write request
  typedef struct packed {
    logic                    en;
    logic [PT_ADDR_BITS-1:0] addr;
  } mem_wr_t;

  // default profile, quarter degrees; points past the twelfth are zero
  function automatic logic [15:0] default_point(input logic [5:0] idx);
    logic [15:0] val;
    unique case (idx)
      6'd0:    val = 16'd100;
      6'd1:    val = 16'd232;
      6'd2:    val = 16'd348;
      6'd3:    val = 16'd452;
      6'd4:    val = 16'd544;
      6'd5:    val = 16'd620;
      6'd6:    val = 16'd684;
      6'd7:    val = 16'd736;
      6'd8:    val = 16'd772;
      6'd9:    val = 16'd796;
      6'd10:   val = 16'd816;
      6'd11:   val = 16'd818;
      default: val = 16'd0;
    endcase
    return val;
  endfunction

endpackage

@@ design/rps_if.sv @@
// rps_if: valid/ready channels of the roast profile sequencer
// uses rps_pkg for field widths

interface rps_in_if #(
  parameter int TEMP_BITS = 12
);
  logic                           valid;
  logic                           ready;
  logic [rps_pkg::OP_BITS-1:0]    op;
  logic [TEMP_BITS-1:0]           temp_a;
  logic                           temp_a_ok;
  logic [TEMP_BITS-1:0]           temp_b;
  logic                           temp_b_ok;
  logic [rps_pkg::PIDX_BITS-1:0]  point_index;
  logic [TEMP_BITS-1:0]           point_value;

  modport source (
    output valid, op, temp_a, temp_a_ok, temp_b, temp_b_ok, point_index, point_value,
    input  ready
  );
  modport sink (
    input  valid, op, temp_a, temp_a_ok, temp_b, temp_b_ok, point_index, point_value,
    output ready
  );
endinterface

interface rps_out_if #(
  parameter int TEMP_BITS = 12
);
  logic                            valid;
  logic                            ready;
  logic [rps_pkg::PHASE_BITS-1:0]  phase;
  logic [TEMP_BITS-1:0]            target_temp;
  logic [TEMP_BITS-1:0]            mean_temp;
  logic                            sample_taken;
  logic [rps_pkg::FAN_BITS-1:0]    fan_level;
  logic                            heat_enable;
  logic [rps_pkg::SECS_BITS-1:0]   elapsed_seconds;
  logic [rps_pkg::STAGE_BITS-1:0]  stage_index;

  modport source (
    output valid, phase, target_temp, mean_temp, sample_taken, fan_level, heat_enable,
           elapsed_seconds, stage_index,
    input  ready
  );
  modport sink (
    input  valid, phase, target_temp, mean_temp, sample_taken, fan_level, heat_enable,
           elapsed_seconds, stage_index,
    output ready
  );
endinterface

interface rps_cfg_if #(
  parameter int TEMP_BITS = 12
);
  logic                              valid;
  logic                              ready;
  logic [rps_pkg::CFG_IDX_BITS-1:0]  index;
  logic [TEMP_BITS-1:0]              data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

@@ design/rps_profile_mem.sv @@
// rps_profile_mem: profile point store, one write port, two registered read ports
// entries not yet written read as the default profile; uses rps_pkg

module rps_profile_mem #(
  parameter int PROFILE_POINTS = 16,
  parameter int TEMP_BITS      = 12
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  rps_pkg::mem_wr_t                 wr_i,
  input  logic [TEMP_BITS-1:0]             wdata_i,
  input  logic [rps_pkg::PT_ADDR_BITS-1:0] raddr_i [2],
  output logic [TEMP_BITS-1:0]             rdata_o [2]
);

  localparam int AW = (PROFILE_POINTS > 1) ? $clog2(PROFILE_POINTS) : 1;
  localparam int XW = (AW > rps_pkg::PT_ADDR_BITS) ? AW : rps_pkg::PT_ADDR_BITS;

  logic [TEMP_BITS-1:0]      mem_q [PROFILE_POINTS];
  logic [PROFILE_POINTS-1:0] vld_q;
  logic [XW-1:0]             wx;
  logic [AW-1:0]             widx;
  logic                      wen;

  assign wx   = XW'(wr_i.addr);
  assign widx = wx[AW-1:0];
  assign wen  = wr_i.en && (int'(wr_i.addr) < PROFILE_POINTS);

  always_ff @(posedge clk_i) begin
    if (wen) begin
      mem_q[widx] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wen) begin
      vld_q[widx] <= 1'b1;
    end
  end

  for (genvar g = 0; g < 2; g++) begin : g_rd
    logic [XW-1:0]        rx;
    logic [AW-1:0]        ridx;
    logic                 rin;
    logic                 byp;
    logic [TEMP_BITS-1:0] mem_rd_q;
    logic [TEMP_BITS-1:0] alt_q;
    logic                 use_mem_q;

    assign rx   = XW'(raddr_i[g]);
    assign ridx = rx[AW-1:0];
    assign rin  = int'(raddr_i[g]) < PROFILE_POINTS;
    // write-first: a read of the entry written at the same edge sees the new data
    assign byp  = wen && (widx == ridx) && rin;

    always_ff @(posedge clk_i) begin
      mem_rd_q <= mem_q[ridx];
      if (byp) begin
        alt_q <= wdata_i;
      end else if (rin) begin
        alt_q <= TEMP_BITS'(rps_pkg::default_point(6'(ridx)));
      end else begin
        alt_q <= '0;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        use_mem_q <= 1'b0;
      end else begin
        use_mem_q <= rin && vld_q[ridx] && !byp;
      end
    end

    assign rdata_o[g] = use_mem_q ? mem_rd_q : alt_q;
  end

endmodule

@@ design/rps_setpoint.sv @@
// rps_setpoint: linear interpolation between two profile points by seconds in the minute
// truncates towards zero; uses rps_pkg for the timing constants

module rps_setpoint #(
  parameter int TEMP_BITS = 12
) (
  input  logic [TEMP_BITS-1:0]         lo_i,
  input  logic [TEMP_BITS-1:0]         hi_i,
  input  logic [rps_pkg::SEC_BITS-1:0] sec_i,
  output logic [TEMP_BITS-1:0]         setpoint_o
);

  // ceil(sec * 2^KW / 60): exact floor of mag*sec/60 for any mag below 2^TEMP_BITS
  localparam int KW = TEMP_BITS + rps_pkg::SEC_BITS;
  localparam int PW = TEMP_BITS + KW;
  localparam int TabLen = 2 ** rps_pkg::SEC_BITS;

  logic [KW-1:0]        ktab [TabLen];
  logic                 neg;
  logic [TEMP_BITS-1:0] mag;
  logic [PW-1:0]        prod;
  logic [TEMP_BITS-1:0] quot;

  for (genvar g = 0; g < TabLen; g++) begin : g_ktab
    localparam longint KVal = (g < rps_pkg::SEC_PER_MIN) ?
      ((longint'(g) << KW) + rps_pkg::SEC_PER_MIN - 1) / rps_pkg::SEC_PER_MIN : 0;
    assign ktab[g] = KW'(KVal);
  end

  assign neg        = hi_i < lo_i;
  assign mag        = neg ? (lo_i - hi_i) : (hi_i - lo_i);
  assign prod       = PW'(mag) * PW'(ktab[sec_i]);
  assign quot       = prod[PW-1:KW];
  assign setpoint_o = neg ? (lo_i - quot) : (lo_i + quot);

endmodule

@@ design/roast_profile_sequencer.sv @@
// roast_profile_sequencer: top level, input stage, phase control and result register
// uses rps_pkg, rps_if, rps_profile_mem and rps_setpoint

// Roast sequencer in quarter degrees Celsius. Each input transfer carries one
// operation: a two-sensor sample, a one-second tick, a roast start or a write of
// one profile point; each gives exactly one result transfer holding phase,
// setpoint, mean temperature, fan level, heater enable, elapsed time and stage.
// One operation is taken per clock while the result register is free or
// drains: the operation is held in an input register, worked through in
// combinational logic whose longest path is one TEMP_BITS x (TEMP_BITS+6)
// multiply in the setpoint interpolation, and lands in the result register,
// from which the result is offered.
// A new input transfer is taken while a result still waits, as long as the
// input register is free or moves on in that cycle. The profile store is a
// small memory with registered reads; the two points around the current stage
// are fetched ahead, addressed from the next state. It needs no clearing pass:
// per-entry valid bits make unwritten points read as the default profile.
// Configuration writes are taken at any time (ready is always high) and should
// only be made while no operation is outstanding.

module roast_profile_sequencer #(
  parameter int PROFILE_POINTS = 16,
  parameter int TEMP_BITS      = 12
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rps_cfg_if.sink   cfg_i,
  rps_in_if.sink    in_i,
  rps_out_if.source out_o
);

  localparam int T = TEMP_BITS;

  // configuration registers
  logic [T-1:0]                   cool_thresh_q;
  logic [rps_pkg::MIN_BITS-1:0]   roast_minutes_q;
  logic [rps_pkg::FAN_BITS-1:0]   fan_start_q;
  logic [rps_pkg::FAN_BITS-1:0]   fan_floor_q;

  // input register
  logic                           in_vld_q;
  rps_pkg::op_e                   in_op_q;
  logic [T-1:0]                   in_ta_q;
  logic                           in_aok_q;
  logic [T-1:0]                   in_tb_q;
  logic                           in_bok_q;
  logic [rps_pkg::PIDX_BITS-1:0]  in_pidx_q;
  logic [T-1:0]                   in_pval_q;

  // sequencer state
  logic [rps_pkg::PHASE_BITS-1:0] phase_q, phase_d;
  logic [rps_pkg::SECS_BITS-1:0]  secs_q, secs_d;
  logic [rps_pkg::SEC_BITS-1:0]   sec_q, sec_d;
  logic [rps_pkg::STAGE_BITS-1:0] stage_q, stage_d;
  logic [rps_pkg::FAN_BITS-1:0]   fan_q, fan_d;
  logic [T-1:0]                   avg_q, avg_d;
  logic [T-1:0]                   setp_q, setp_d;

  // result register
  logic                           out_vld_q;
  logic [rps_pkg::PHASE_BITS-1:0] out_phase_q;
  logic [T-1:0]                   out_target_q;
  logic [T-1:0]                   out_mean_q;
  logic                           out_taken_q;
  logic [rps_pkg::FAN_BITS-1:0]   out_fan_q;
  logic                           out_heat_q;
  logic [rps_pkg::SECS_BITS-1:0]  out_secs_q;
  logic [rps_pkg::STAGE_BITS-1:0] out_stage_q;

  logic                           fire;
  logic                           taken;
  logic [T-1:0]                   s_one;
  logic [T-1:0]                   s_two;
  logic [T:0]                     s_sum;
  logic [rps_pkg::SEC_BITS-1:0]   sec_inc;
  logic [rps_pkg::SECS_BITS-1:0]  half_secs;
  logic [rps_pkg::SECS_BITS-1:0]  full_secs;
  logic [rps_pkg::STAGE_BITS-1:0] stage_rd;
  logic [T-1:0]                   interp;
  rps_pkg::mem_wr_t               wr_req;
  rps_pkg::mem_wr_t               mem_wr;
  logic [T-1:0]                   mem_wdata;
  logic [rps_pkg::PT_ADDR_BITS-1:0] raddr [2];
  logic [T-1:0]                   rdata [2];

  // ---------------------------------------------------------------------------
  // handshakes: the work step fires when the result register is free or drains
  // ---------------------------------------------------------------------------
  assign fire        = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready  = !in_vld_q || fire;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_op_q   <= rps_pkg::op_e'(in_i.op);
      in_ta_q   <= in_i.temp_a;
      in_aok_q  <= in_i.temp_a_ok;
      in_tb_q   <= in_i.temp_b;
      in_bok_q  <= in_i.temp_b_ok;
      in_pidx_q <= in_i.point_index;
      in_pval_q <= in_i.point_value;
    end
  end

  // ---------------------------------------------------------------------------
  // configuration registers, unknown indexes are dropped
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cool_thresh_q   <= T'(rps_pkg::RESET_COOL_THRESH);
      roast_minutes_q <= rps_pkg::MIN_BITS'(rps_pkg::RESET_ROAST_MINUTES);
      fan_start_q     <= rps_pkg::FAN_BITS'(rps_pkg::RESET_FAN_START);
      fan_floor_q     <= rps_pkg::FAN_BITS'(rps_pkg::RESET_FAN_FLOOR);
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        rps_pkg::CFG_COOL_THRESHOLD: cool_thresh_q   <= cfg_i.data;
        rps_pkg::CFG_ROAST_MINUTES:  roast_minutes_q <= cfg_i.data[rps_pkg::MIN_BITS-1:0];
        rps_pkg::CFG_FAN_START:      fan_start_q     <= cfg_i.data[rps_pkg::FAN_BITS-1:0];
        rps_pkg::CFG_FAN_FLOOR:      fan_floor_q     <= cfg_i.data[rps_pkg::FAN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // profile store: reads are addressed from the state of the next cycle
  // port 0 gives point[stage], port 1 point[stage+1]
  // ---------------------------------------------------------------------------
  assign stage_rd = fire ? stage_d : stage_q;
  assign raddr[0] = rps_pkg::PT_ADDR_BITS'(stage_rd);
  assign raddr[1] = rps_pkg::PT_ADDR_BITS'(stage_rd) + rps_pkg::PT_ADDR_BITS'(1);

  assign mem_wr.en   = wr_req.en && fire;
  assign mem_wr.addr = wr_req.addr;

  rps_profile_mem #(
    .PROFILE_POINTS (PROFILE_POINTS),
    .TEMP_BITS      (TEMP_BITS)
  ) u_profile_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (mem_wr),
    .wdata_i (mem_wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // seconds into the stage after this tick, when it does not close the minute
  assign sec_inc = sec_q + rps_pkg::SEC_BITS'(1);

  rps_setpoint #(
    .TEMP_BITS (TEMP_BITS)
  ) u_setpoint (
    .lo_i       (rdata[0]),
    .hi_i       (rdata[1]),
    .sec_i      (sec_inc),
    .setpoint_o (interp)
  );

  assign half_secs = rps_pkg::SECS_BITS'(roast_minutes_q)
                   * rps_pkg::SECS_BITS'(rps_pkg::HALF_MIN);
  assign full_secs = rps_pkg::SECS_BITS'(roast_minutes_q)
                   * rps_pkg::SECS_BITS'(rps_pkg::SEC_PER_MIN);

  // ---------------------------------------------------------------------------
  // one operation: sample, then phase logic, then start or point write
  // ---------------------------------------------------------------------------
  always_comb begin
    // sensor fusion: an open sensor takes the other reading
    taken = (in_op_q == rps_pkg::OP_SAMPLE) && (in_aok_q || in_bok_q);
    s_one = in_aok_q ? in_ta_q : in_tb_q;
    s_two = in_bok_q ? in_tb_q : in_ta_q;
    s_sum = {1'b0, s_one} + {1'b0, s_two};
    avg_d = taken ? s_sum[T:1] : avg_q;

    phase_d     = phase_q;
    secs_d      = secs_q;
    sec_d       = sec_q;
    stage_d     = stage_q;
    fan_d       = fan_q;
    setp_d      = setp_q;
    wr_req.en   = 1'b0;
    wr_req.addr = '0;
    mem_wdata   = in_pval_q;

    unique case (phase_q)
      rps_pkg::PH_ROAST: begin
        if (in_op_q == rps_pkg::OP_TICK) begin
          secs_d = secs_q + rps_pkg::SECS_BITS'(1);
          if (sec_q == rps_pkg::SEC_BITS'(rps_pkg::SEC_PER_MIN - 1)) begin
            // minute closes: next stage, setpoint sits on its first point
            sec_d   = '0;
            stage_d = stage_q + rps_pkg::STAGE_BITS'(1);
            setp_d  = rdata[1];
          end else begin
            sec_d  = sec_inc;
            setp_d = interp;
          end
          // second half: fan steps down one level a tick to its floor
          if ((secs_d >= half_secs) && (fan_q > fan_floor_q)) begin
            fan_d = fan_q - rps_pkg::FAN_BITS'(1);
          end
        end
        if (secs_d >= full_secs) begin
          phase_d = rps_pkg::PH_COOL;
        end
      end
      rps_pkg::PH_COOL: begin
        if (avg_d <= cool_thresh_q) begin
          phase_d = rps_pkg::PH_MENU;
        end
      end
      default: ;
    endcase

    // start and profile writes only act in the menu, also right after cooling ends
    if (phase_d == rps_pkg::PH_MENU) begin
      if (in_op_q == rps_pkg::OP_START) begin
        wr_req.en   = 1'b1;
        wr_req.addr = '0;
        mem_wdata   = avg_d;
        setp_d      = avg_d;
        stage_d     = '0;
        secs_d      = '0;
        sec_d       = '0;
        fan_d       = fan_start_q;
        phase_d     = rps_pkg::PH_ROAST;
      end else if (in_op_q == rps_pkg::OP_WRITE) begin
        wr_req.en   = 1'b1;
        wr_req.addr = rps_pkg::PT_ADDR_BITS'(in_pidx_q);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // state update
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= rps_pkg::PH_MENU;
      secs_q  <= '0;
      sec_q   <= '0;
      stage_q <= '0;
      fan_q   <= '0;
      avg_q   <= T'(rps_pkg::RESET_TEMP);
      setp_q  <= T'(rps_pkg::RESET_TEMP);
    end else if (fire) begin
      phase_q <= phase_d;
      secs_q  <= secs_d;
      sec_q   <= sec_d;
      stage_q <= stage_d;
      fan_q   <= fan_d;
      avg_q   <= avg_d;
      setp_q  <= setp_d;
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_phase_q  <= phase_d;
      out_target_q <= setp_d;
      out_mean_q   <= avg_d;
      out_taken_q  <= taken;
      out_fan_q    <= (phase_d == rps_pkg::PH_MENU) ? '0 : fan_d;
      out_heat_q   <= (phase_d == rps_pkg::PH_ROAST);
      out_secs_q   <= secs_d;
      out_stage_q  <= stage_d;
    end
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.phase           = out_phase_q;
  assign out_o.target_temp     = out_target_q;
  assign out_o.mean_temp       = out_mean_q;
  assign out_o.sample_taken    = out_taken_q;
  assign out_o.fan_level       = out_fan_q;
  assign out_o.heat_enable     = out_heat_q;
  assign out_o.elapsed_seconds = out_secs_q;
  assign out_o.stage_index     = out_stage_q;

endmodule

@@ test/tb_top.sv @@
// tb_top: self-checking testbench for roast_profile_sequencer
// depends on rps_pkg, the rps_if channel interfaces and the design files under design/
// a mirror of the sequencer, stepped once per operation, predicts every result transfer

`timescale 1ns / 100ps

module tb_top;
  import rps_pkg::*;

  localparam int PROFILE_POINTS = 16;
  localparam int TEMP_BITS      = 12;
  localparam int TEMP_MAX       = (1 << TEMP_BITS) - 1;
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_CYCLES   = 10;
  localparam int HOLD_CYCLES    = 300;     // long receiver hold-off
  localparam int CYCLE_LIMIT    = 1000000;

  // one input transfer
  typedef struct packed {
    op_e                  op;
    logic [TEMP_BITS-1:0] temp_a;
    logic                 temp_a_ok;
    logic [TEMP_BITS-1:0] temp_b;
    logic                 temp_b_ok;
    logic [3:0]           point_index;
    logic [TEMP_BITS-1:0] point_value;
  } roast_cmd_t;

  // one result transfer
  typedef struct packed {
    logic [PHASE_BITS-1:0] phase;
    logic [TEMP_BITS-1:0]  target_temp;
    logic [TEMP_BITS-1:0]  mean_temp;
    logic                  sample_taken;
    logic [FAN_BITS-1:0]   fan_level;
    logic                  heat_enable;
    logic [SECS_BITS-1:0]  elapsed_seconds;
    logic [STAGE_BITS-1:0] stage_index;
  } roast_status_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  rps_cfg_if #(.TEMP_BITS(TEMP_BITS)) cfg_ch ();
  rps_in_if  #(.TEMP_BITS(TEMP_BITS)) in_ch ();
  rps_out_if #(.TEMP_BITS(TEMP_BITS)) out_ch ();

  roast_profile_sequencer #(
    .PROFILE_POINTS(PROFILE_POINTS),
    .TEMP_BITS     (TEMP_BITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_ch),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always #5 clk_i = ~clk_i;

  // mirror of the sequencer: settings, profile store and roast state
  logic [TEMP_BITS-1:0]  cfg_cool_thr;
  logic [MIN_BITS-1:0]   cfg_minutes;
  logic [FAN_BITS-1:0]   cfg_fan_start;
  logic [FAN_BITS-1:0]   cfg_fan_floor;
  logic [TEMP_BITS-1:0]  m_store [PROFILE_POINTS];
  logic [PHASE_BITS-1:0] m_phase;
  logic [SECS_BITS-1:0]  m_secs;
  logic [STAGE_BITS-1:0] m_stage;
  logic [FAN_BITS-1:0]   m_fan;
  logic [TEMP_BITS-1:0]  m_one;
  logic [TEMP_BITS-1:0]  m_two;
  logic [TEMP_BITS-1:0]  m_mean;
  logic [TEMP_BITS-1:0]  m_setpoint;

  // results still owed by the block, oldest first
  roast_status_t status_due_q [$];

  int fault_cnt    = 0;
  bit no_gaps      = 1'b0;  // both sides run flat out while set
  int hold_req_cnt = 0;     // bumped to ask the receiver for a long hold-off
  int hold_seen    = 0;

  function automatic void reset_model();
    cfg_cool_thr  = TEMP_BITS'(RESET_COOL_THRESH);
    cfg_minutes   = MIN_BITS'(RESET_ROAST_MINUTES);
    cfg_fan_start = FAN_BITS'(RESET_FAN_START);
    cfg_fan_floor = FAN_BITS'(RESET_FAN_FLOOR);
    // factory profile, the last four points empty
    m_store = '{12'd100, 12'd232, 12'd348, 12'd452, 12'd544, 12'd620, 12'd684, 12'd736,
                12'd772, 12'd796, 12'd816, 12'd818, 12'd0, 12'd0, 12'd0, 12'd0};
    m_phase    = PH_MENU;
    m_secs     = '0;
    m_stage    = '0;
    m_fan      = '0;
    m_one      = TEMP_BITS'(RESET_TEMP);
    m_two      = TEMP_BITS'(RESET_TEMP);
    m_mean     = TEMP_BITS'(RESET_TEMP);
    m_setpoint = TEMP_BITS'(RESET_TEMP);
  endfunction

  // points past the end of the store read as zero
  function automatic int point_or_zero(input int idx);
    if (idx >= PROFILE_POINTS) return 0;
    return int'(m_store[idx]);
  endfunction

  // apply one operation to the mirror and return the status it produces
  function automatic roast_status_t advance_roast(input roast_cmd_t c);
    roast_status_t r;
    logic [TEMP_BITS:0] sum;
    logic taken;
    int sec;
    int lo;
    int hi;
    int v;
    taken = 1'b0;
    // sensor fusion: a dead sensor borrows the other one, both dead keeps the old values
    if (c.op == OP_SAMPLE && (c.temp_a_ok || c.temp_b_ok)) begin
      m_one  = c.temp_a_ok ? c.temp_a : c.temp_b;
      m_two  = c.temp_b_ok ? c.temp_b : c.temp_a;
      sum    = {1'b0, m_one} + {1'b0, m_two};
      m_mean = sum[TEMP_BITS:1];
      taken  = 1'b1;
    end
    if (m_phase == PH_ROAST) begin
      if (c.op == OP_TICK) begin
        m_secs = m_secs + 1'b1;
        sec    = int'(m_secs) % SEC_PER_MIN;
        if (sec == 0) m_stage = m_stage + 1'b1;
        // linear interpolation between the two points around this stage
        lo = point_or_zero(int'(m_stage));
        hi = point_or_zero(int'(m_stage) + 1);
        v  = lo + ((hi - lo) * sec) / SEC_PER_MIN;
        if (v < 0) v = 0;
        m_setpoint = v[TEMP_BITS-1:0];
        // second half: fan creeps down to its floor
        if (int'(m_secs) >= int'(cfg_minutes) * HALF_MIN && m_fan > cfg_fan_floor)
          m_fan = m_fan - 1'b1;
      end
      if (int'(m_secs) >= int'(cfg_minutes) * SEC_PER_MIN) m_phase = PH_COOL;
    end else if (m_phase == PH_COOL) begin
      if (m_mean <= cfg_cool_thr) m_phase = PH_MENU;
    end
    // start and profile edits only act from the menu, after the phase update
    if (m_phase == PH_MENU) begin
      if (c.op == OP_START) begin
        m_store[0] = m_mean;
        m_setpoint = m_mean;
        m_stage    = '0;
        m_secs     = '0;
        m_fan      = cfg_fan_start;
        m_phase    = PH_ROAST;
      end else if (c.op == OP_WRITE) begin
        m_store[c.point_index] = c.point_value;
      end
    end
    r.phase           = m_phase;
    r.target_temp     = m_setpoint;
    r.mean_temp       = m_mean;
    r.sample_taken    = taken;
    r.fan_level       = (m_phase == PH_MENU) ? '0 : m_fan;
    r.heat_enable     = (m_phase == PH_ROAST);
    r.elapsed_seconds = m_secs;
    r.stage_index     = m_stage;
    return r;
  endfunction

  // idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic roast_cmd_t random_cmd();
    roast_cmd_t c;
    c.op          = op_e'($urandom_range(0, 3));
    c.temp_a      = TEMP_BITS'($urandom_range(0, TEMP_MAX));
    c.temp_a_ok   = ($urandom_range(0, 3) != 0);
    c.temp_b      = TEMP_BITS'($urandom_range(0, TEMP_MAX));
    c.temp_b_ok   = ($urandom_range(0, 3) != 0);
    c.point_index = 4'($urandom_range(0, PROFILE_POINTS - 1));
    c.point_value = TEMP_BITS'($urandom_range(0, TEMP_MAX));
    return c;
  endfunction

  function automatic roast_cmd_t op_cmd(input op_e op);
    roast_cmd_t c;
    c    = random_cmd();
    c.op = op;
    return c;
  endfunction

  function automatic roast_cmd_t sample_cmd(input int a, input bit a_ok, input int b,
                                            input bit b_ok);
    roast_cmd_t c;
    c           = op_cmd(OP_SAMPLE);
    c.temp_a    = TEMP_BITS'(a);
    c.temp_a_ok = a_ok;
    c.temp_b    = TEMP_BITS'(b);
    c.temp_b_ok = b_ok;
    return c;
  endfunction

  function automatic roast_cmd_t point_cmd(input int idx, input int val);
    roast_cmd_t c;
    c             = op_cmd(OP_WRITE);
    c.point_index = 4'(idx);
    c.point_value = TEMP_BITS'(val);
    return c;
  endfunction

  // offer one operation, wait for its transfer, then book the expected status;
  // valid is left high so that a following item can go out back to back
  task automatic send_cmd(input roast_cmd_t c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.op          <= c.op;
    in_ch.temp_a      <= c.temp_a;
    in_ch.temp_a_ok   <= c.temp_a_ok;
    in_ch.temp_b      <= c.temp_b;
    in_ch.temp_b_ok   <= c.temp_b_ok;
    in_ch.point_index <= c.point_index;
    in_ch.point_value <= c.point_value;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    status_due_q.push_back(advance_roast(c));
  endtask

  // stop offering and let every owed result come back
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (status_due_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // one register write transfer; valid stays high for a following write
  task automatic write_setting(input logic [CFG_IDX_BITS-1:0] idx, input int val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= TEMP_BITS'(val);
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    case (idx)
      CFG_COOL_THRESHOLD: cfg_cool_thr  = TEMP_BITS'(val);
      CFG_ROAST_MINUTES:  cfg_minutes   = MIN_BITS'(val);
      CFG_FAN_START:      cfg_fan_start = FAN_BITS'(val);
      CFG_FAN_FLOOR:      cfg_fan_floor = FAN_BITS'(val);
      default: ;
    endcase
  endtask

  task automatic apply_settings(input int thr, input int mins, input int fan_start,
                                input int fan_floor);
    settle();
    write_setting(CFG_COOL_THRESHOLD, thr);
    write_setting(CFG_ROAST_MINUTES, mins);
    write_setting(CFG_FAN_START, fan_start);
    write_setting(CFG_FAN_FLOOR, fan_floor);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // extremes of the readings, single dead sensors and both dead
  task automatic test_sensor_fusion();
    send_cmd(sample_cmd(TEMP_MAX, 1'b0, TEMP_MAX, 1'b0));
    send_cmd(sample_cmd(TEMP_MAX, 1'b1, 0, 1'b0));
    send_cmd(sample_cmd(0, 1'b0, 0, 1'b1));
    send_cmd(sample_cmd(TEMP_MAX, 1'b1, TEMP_MAX, 1'b1));
    send_cmd(sample_cmd(0, 1'b1, TEMP_MAX, 1'b1));
    send_cmd(sample_cmd('hAAA, 1'b1, 'h555, 1'b1));
    // a tick in the menu does nothing
    send_cmd(op_cmd(OP_TICK));
  endtask

  task automatic test_profile_points();
    send_cmd(point_cmd(0, 0));
    send_cmd(point_cmd(PROFILE_POINTS - 1, TEMP_MAX));
    send_cmd(point_cmd(5, 'hAAA));
    send_cmd(point_cmd(10, 'h555));
  endtask

  // zero-length roast: ignored starts, edits and ticks outside the menu,
  // and a start arriving on the very step that cooling finishes
  task automatic test_zero_duration();
    apply_settings(RESET_COOL_THRESH, 0, 255, 0);
    send_cmd(sample_cmd(300, 1'b1, 300, 1'b1));
    send_cmd(op_cmd(OP_START));
    send_cmd(op_cmd(OP_START));              // roast ends here, start dropped
    send_cmd(point_cmd(3, TEMP_MAX));        // cooling, write dropped
    send_cmd(op_cmd(OP_TICK));               // cooling, tick dropped
    send_cmd(sample_cmd(0, 1'b1, 0, 1'b1));  // cool enough, back to menu
    send_cmd(op_cmd(OP_START));
    send_cmd(op_cmd(OP_TICK));               // roast over, cooling this step
    send_cmd(op_cmd(OP_START));              // cooling ends and roast restarts at once
    send_cmd(sample_cmd(TEMP_MAX, 1'b1, 0, 1'b0));
    send_cmd(sample_cmd(100, 1'b1, 100, 1'b1));
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    int i;
    settle();
    no_gaps = 1'b1;
    hold_req_cnt++;
    for (i = 0; i < 40; i++) send_cmd(op_cmd($urandom_range(0, 1) ? OP_SAMPLE : OP_WRITE));
    no_gaps = 1'b0;
  endtask

  // mostly well-formed roasts with random content, a little noise in between
  task automatic run_roast_traffic(input int n_items);
    roast_cmd_t c;
    int done_cnt;
    int r;
    done_cnt = 0;
    while (done_cnt < n_items) begin
      c = random_cmd();
      r = $urandom_range(0, 99);
      if (r < 8) begin
        // stray operation of any kind; mostly ignored by the block
        send_cmd(c);
      end else begin
        case (m_phase)
          PH_MENU: begin
            if (r < 40)      c.op = OP_WRITE;
            else if (r < 75) c.op = OP_SAMPLE;
            else             c.op = OP_START;
          end
          PH_ROAST: c.op = (r < 88) ? OP_TICK : OP_SAMPLE;
          default: begin
            // cooling: pull the mean under the threshold about half the time
            c.op = OP_SAMPLE;
            if (r < 55) begin
              c.temp_a = TEMP_BITS'($urandom_range(0, int'(cfg_cool_thr)));
              c.temp_b = TEMP_BITS'($urandom_range(0, int'(cfg_cool_thr)));
            end
          end
        endcase
        send_cmd(c);
        done_cnt++;
      end
    end
  endtask

  task automatic test_random_settings();
    apply_settings(TEMP_MAX, 1, 255, 0);
    run_roast_traffic(150);
    apply_settings(0, 2, 0, 255);
    run_roast_traffic(150);
    apply_settings($urandom_range(0, TEMP_MAX), 1, $urandom_range(0, 255),
                   $urandom_range(0, 255));
    run_roast_traffic(150);
    no_gaps = 1'b1;
    apply_settings(RESET_COOL_THRESH, 3, RESET_FAN_START, RESET_FAN_FLOOR);
    run_roast_traffic(150);
    no_gaps = 1'b0;
  endtask

  // full fifteen-minute roast: last stage reads past the store, fan hits zero
  task automatic test_long_roast();
    roast_cmd_t c;
    int i;
    apply_settings(TEMP_MAX, 15, 255, 0);
    for (i = 0; i < PROFILE_POINTS; i++) send_cmd(point_cmd(i, $urandom_range(0, TEMP_MAX)));
    send_cmd(sample_cmd($urandom_range(0, TEMP_MAX), 1'b1, $urandom_range(0, TEMP_MAX), 1'b1));
    send_cmd(op_cmd(OP_START));
    while (m_phase == PH_ROAST) begin
      c = random_cmd();
      c.op = ($urandom_range(0, 9) == 0) ? OP_SAMPLE : OP_TICK;
      send_cmd(c);
    end
    send_cmd(op_cmd(OP_SAMPLE));
  endtask

  function automatic void report_fault(input string what, input roast_status_t want,
                                       input roast_status_t got);
    fault_cnt++;
    if (fault_cnt <= 10) begin
      $display("[%0t] %s", $time, what);
      $display("  expected: ph=%0d tgt=%0d mean=%0d took=%0b fan=%0d heat=%0b sec=%0d stg=%0d",
               want.phase, want.target_temp, want.mean_temp, want.sample_taken,
               want.fan_level, want.heat_enable, want.elapsed_seconds, want.stage_index);
      $display("  actual:   ph=%0d tgt=%0d mean=%0d took=%0b fan=%0d heat=%0b sec=%0d stg=%0d",
               got.phase, got.target_temp, got.mean_temp, got.sample_taken,
               got.fan_level, got.heat_enable, got.elapsed_seconds, got.stage_index);
    end
  endfunction

  // every result transfer is matched against the oldest owed status
  always @(posedge clk_i) begin : result_check
    roast_status_t got;
    roast_status_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.phase           = out_ch.phase;
      got.target_temp     = out_ch.target_temp;
      got.mean_temp       = out_ch.mean_temp;
      got.sample_taken    = out_ch.sample_taken;
      got.fan_level       = out_ch.fan_level;
      got.heat_enable     = out_ch.heat_enable;
      got.elapsed_seconds = out_ch.elapsed_seconds;
      got.stage_index     = out_ch.stage_index;
      if (status_due_q.size() == 0) begin
        report_fault("result transfer with nothing outstanding", got, got);
      end else begin
        want = status_due_q.pop_front();
        if (got !== want) report_fault("result mismatch", want, got);
      end
    end
  end

  // receiver: random stalls, plus the long hold-off when asked for one
  initial begin : result_sink
    int stall;
    int held;
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_req_cnt) begin
        hold_seen = hold_req_cnt;
        out_ch.ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk_i);
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      out_ch.ready <= 1'b1;
    end
  end

  // watchdog: a hung handshake ends the run
  initial begin : watchdog
    int unsigned cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : test_sequence
    rst_ni            <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.op          <= OP_SAMPLE;
    in_ch.temp_a      <= '0;
    in_ch.temp_a_ok   <= 1'b0;
    in_ch.temp_b      <= '0;
    in_ch.temp_b_ok   <= 1'b0;
    in_ch.point_index <= '0;
    in_ch.point_value <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= CFG_COOL_THRESHOLD;
    cfg_ch.data       <= '0;
    reset_model();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_sensor_fusion();
    test_profile_points();
    test_zero_duration();
    test_backpressure();
    test_random_settings();
    test_long_roast();

    // drain and give any stray transfer time to show up
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (status_due_q.size() != 0) begin
      fault_cnt++;
      $display("%0d results never arrived", status_due_q.size());
    end
    if (fault_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/rps_pkg.sv
design/rps_if.sv
design/rps_profile_mem.sv
design/rps_setpoint.sv
design/roast_profile_sequencer.sv
test/tb_top.sv
